// ----- src/sobel_edge_magnitude_rgba_macros.svh -----
// assertion macros for the sobel edge block
`ifndef SOBEL_EDGE_MAGNITUDE_RGBA_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGBA_MACROS_SVH
`define SEM_ASSERT_IMP(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define SEM_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

// ----- src/sem_pkg.sv -----
// shared types and constants for the sobel edge block
`default_nettype none
package sem_pkg;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegWidth = 1'b0;
  localparam logic [CfgIdxW-1:0] RegHeight = 1'b1;
  localparam logic [10:0] WidthReset = 11'd640;
  localparam logic [15:0] HeightReset = 16'd480;
  localparam logic [7:0] CapValue = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_ROOT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic mem_read;
    logic upd;
    logic root_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic has_out;
    logic root_done;
    logic out_busy;
  } sts_t;
endpackage
`default_nettype wire

// ----- src/sem_if.sv -----
// valid/ready channel interfaces
`default_nettype none
interface sem_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;
  modport source (output valid, req_type, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink (input valid, req_type, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface sem_out_if;
  logic valid;
  logic ready;
  logic [7:0] red_edge;
  logic [7:0] green_edge;
  logic [7:0] blue_edge;
  logic [7:0] alpha_out;
  logic frame_last;
  modport source (output valid, red_edge, green_edge, blue_edge, alpha_out, frame_last,
    input ready);
  modport sink (input valid, red_edge, green_edge, blue_edge, alpha_out, frame_last,
    output ready);
endinterface

interface sem_cfg_if;
  logic valid;
  logic ready;
  logic [sem_pkg::CfgIdxW-1:0] index;
  logic [sem_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/sem_ctrl.sv -----
// controller state machine
`default_nettype none
module sem_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire sem_pkg::sts_t sts,
  output sem_pkg::cmd_t cmd,
  output logic in_ready
);
  import sem_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) state_next = ST_READ;
      ST_READ: state_next = ST_EMIT;
      ST_EMIT: state_next = sts.has_out ? ST_ROOT : ST_IDLE;
      ST_ROOT: if (sts.root_done) state_next = ST_OUT;
      ST_OUT: if (!sts.out_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_fire;
      end
      ST_READ: cmd.mem_read = 1'b1;
      ST_EMIT: begin
        cmd.upd = 1'b1;
        cmd.root_start = sts.has_out;
      end
      ST_ROOT: ;
      ST_OUT: cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- src/sem_dp.sv -----
// line stores, window, gradient sums and square root datapath
`default_nettype none
module sem_dp #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned COLOR_CHANNELS = 3
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire sem_pkg::cmd_t cmd,
  output sem_pkg::sts_t sts,
  input  wire logic req_type,
  input  wire logic [31:0] px_in,
  input  wire logic [10:0] image_width,
  input  wire logic [15:0] image_height,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [31:0] out_px,
  output logic out_last
);
  import sem_pkg::*;
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = $clog2(MAX_WIDTH + 2);

  logic [31:0] mem_up [MAX_WIDTH];
  logic [31:0] mem_lo [MAX_WIDTH];
  logic [31:0] rd_up, rd_lo;
  logic [31:0] win [9];
  logic [CW-1:0] column_count, pending_outputs;
  logic [15:0] row_count;
  logic rq;
  logic [31:0] px;
  logic [CW-1:0] w;
  logic [15:0] h;
  logic [CW-1:0] c, k;
  logic [15:0] r;
  logic [AW-1:0] addr;
  logic has_out, pix_due;
  logic [15:0] e_cr;
  logic [CW-1:0] e_cc;
  logic e_ci2, e_last;
  logic [15:0] cr;
  logic [CW-1:0] cc;
  logic ci2, last_q;
  logic [7:0] root [4];
  logic [3:0] bitn;
  logic busy;
  logic [31:0] cpx;

  // effective geometry
  always_comb begin
    if (image_width < 11'd2) w = CW'(2);
    else if ({21'd0, image_width} > 32'(MAX_WIDTH)) w = CW'(MAX_WIDTH);
    else w = CW'(image_width);
    h = (image_height < 16'd2) ? 16'd2 : image_height;
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rq <= req_type;
      px <= px_in;
    end
  end

  // position of this item
  always_comb begin
    c = column_count;
    r = row_count;
    if (column_count >= w) begin
      c = '0;
      r = row_count + 16'd1;
    end
    k = (pending_outputs >= w + CW'(1)) ? '0 : w + CW'(1) - pending_outputs;
    addr = rq ? k[AW-1:0] : c[AW-1:0];
    pix_due = (r >= 16'd2) || (r == 16'd1 && c != '0);
    has_out = rq ? (pending_outputs != '0) : pix_due;
    e_last = 1'b0;
    if (!rq) begin
      if (c == '0) begin
        e_cr = r - 16'd2; e_cc = w - CW'(1); e_ci2 = 1'b0;
      end else begin
        e_cr = r - 16'd1; e_cc = c - CW'(1); e_ci2 = 1'b0;
      end
    end else if (k == '0) begin
      e_cr = h - 16'd2; e_cc = w - CW'(1); e_ci2 = 1'b0;
    end else if (k < w) begin
      e_cr = h - 16'd1; e_cc = k - CW'(1); e_ci2 = 1'b0;
    end else begin
      e_cr = h - 16'd1; e_cc = w - CW'(1); e_ci2 = 1'b1; e_last = 1'b1;
    end
  end
  assign sts.has_out = has_out;

  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      rd_up <= mem_up[addr];
      rd_lo <= mem_lo[addr];
    end
    if (cmd.upd && !rq) begin
      mem_up[addr] <= rd_lo;
      mem_lo[addr] <= px;
    end
  end

  // window shift: every pixel shifts the window, and so does each owed drain but the last
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
      column_count <= '0;
      row_count <= '0;
      pending_outputs <= '0;
    end else if (cmd.upd) begin
      if (!rq || (pending_outputs != '0 && k < w)) begin
        for (int j = 0; j < 3; j++) begin
          win[j*3] <= win[j*3+1];
          win[j*3+1] <= win[j*3+2];
        end
        win[2] <= rd_up;
        win[5] <= rd_lo;
        win[8] <= rq ? 32'd0 : px;
      end
      if (!rq) begin
        pending_outputs <= '0;
        if (c + CW'(1) >= w) begin
          column_count <= '0;
          if ({1'b0, r} + 17'd1 >= {1'b0, h}) begin
            row_count <= '0;
            pending_outputs <= w + CW'(1);
          end else row_count <= r + 16'd1;
        end else begin
          column_count <= c + CW'(1);
          row_count <= r;
        end
      end else if (pending_outputs != '0) begin
        pending_outputs <= pending_outputs - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      cr <= e_cr; cc <= e_cc; ci2 <= e_ci2; last_q <= e_last;
    end
  end

  // gradient sums on the window after the update, bit-serial root
  logic [1:0] rs0, rs2, cs0, cs1, cs2;
  logic signed [11:0] gx [4], gy [4];
  logic [23:0] ssum [4];
  function automatic logic signed [11:0] pv(input logic [31:0] p, input int ch);
    return 12'(p[8*ch +: 8]);
  endfunction
  always_comb begin
    rs0 = (cr == 16'd0) ? 2'd1 : 2'd0;
    rs2 = (cr + 16'd1 >= h) ? 2'd1 : 2'd2;
    cs1 = ci2 ? 2'd2 : 2'd1;
    cs0 = (cc == '0) ? cs1 : cs1 - 2'd1;
    cs2 = (cc + CW'(1) >= w || ci2) ? cs1 : cs1 + 2'd1;
    cpx = win[3 + cs1];
    for (int ch = 0; ch < 4; ch++) begin
      gx[ch] = (pv(win[rs0*3+cs2], ch) - pv(win[rs0*3+cs0], ch))
             + 12'sd2 * (pv(win[3+cs2], ch) - pv(win[3+cs0], ch))
             + (pv(win[rs2*3+cs2], ch) - pv(win[rs2*3+cs0], ch));
      gy[ch] = (pv(win[rs0*3+cs0], ch) - pv(win[rs2*3+cs0], ch))
             + 12'sd2 * (pv(win[rs0*3+cs1], ch) - pv(win[rs2*3+cs1], ch))
             + (pv(win[rs0*3+cs2], ch) - pv(win[rs2*3+cs2], ch));
    end
  end

  always_ff @(posedge clk) begin
    logic [7:0] trial;
    logic [16:0] sq;
    if (rst) begin
      busy <= 1'b0;
      bitn <= '0;
    end else if (cmd.root_start) begin
      busy <= 1'b1;
      bitn <= 4'd8;
    end else if (busy) begin
      if (bitn == 4'd8) begin
        for (int ch = 0; ch < 4; ch++) begin
          ssum[ch] <= 24'(gx[ch]) * 24'(gx[ch]) + 24'(gy[ch]) * 24'(gy[ch]);
          root[ch] <= '0;
        end
        bitn <= 4'd7;
      end else begin
        for (int ch = 0; ch < 4; ch++) begin
          trial = root[ch] | (8'd1 << bitn[2:0]);
          sq = 17'(trial) * 17'(trial);
          if (ssum[ch] >= 24'd65536) root[ch] <= CapValue;
          else if ({7'd0, sq} <= ssum[ch]) root[ch] <= trial;
        end
        if (bitn == 4'd0) busy <= 1'b0;
        else bitn <= bitn - 4'd1;
      end
    end
  end
  assign sts.root_done = !busy && !cmd.root_start;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int ch = 0; ch < 4; ch++)
        out_px[8*ch +: 8] <= (ch < int'(COLOR_CHANNELS)) ? root[ch] : cpx[8*ch +: 8];
      out_last <= last_q;
    end
  end
  assign sts.out_busy = out_valid && !out_ready;
endmodule
`default_nettype wire

// ----- src/sobel_edge_magnitude_rgba.sv -----
// top level of the sobel edge block
//  channel | dir | contents
//  in_ch   | in  | req_type, rgba pixel
//  out_ch  | out | edge rgb, alpha, frame_last
//  cfg_ch  | in  | register index, data
// an item passes the idle, read and emit states; one that yields a result then runs the
// root state and waits in the out state; line stores are one-port memories
// reset clears window, counters and registers; line stores stay unset
// a full output register holds the controller until taken
`default_nettype none
module sobel_edge_magnitude_rgba #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned COLOR_CHANNELS = 3
) (
  input wire logic clk,
  input wire logic rst,
  sem_in_if.sink in_ch,
  sem_out_if.source out_ch,
  sem_cfg_if.sink cfg_ch
);
  import sem_pkg::*;
  `include "sobel_edge_magnitude_rgba_macros.svh"
  cmd_t cmd;
  sts_t sts;
  logic [10:0] image_width;
  logic [15:0] image_height;
  logic [31:0] opx;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WidthReset;
      image_height <= HeightReset;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        RegWidth: image_width <= cfg_ch.data[10:0];
        RegHeight: image_height <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  sem_ctrl u_ctrl (.clk, .rst, .in_fire(in_ch.valid && in_ch.ready), .sts, .cmd,
    .in_ready(in_ch.ready));

  sem_dp #(.MAX_WIDTH(MAX_WIDTH), .COLOR_CHANNELS(COLOR_CHANNELS)) u_dp (
    .clk, .rst, .cmd, .sts, .req_type(in_ch.req_type),
    .px_in({in_ch.alpha_in, in_ch.blue_in, in_ch.green_in, in_ch.red_in}),
    .image_width, .image_height, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_px(opx), .out_last(out_ch.frame_last));

  assign out_ch.red_edge = opx[7:0];
  assign out_ch.green_edge = opx[15:8];
  assign out_ch.blue_edge = opx[23:16];
  assign out_ch.alpha_out = opx[31:24];

  `SEM_ASSERT_IMP(a_load_free, clk, rst, cmd.out_load, !sts.out_busy, "load over full word")
  `SEM_ASSERT_NEXT(a_take_read, clk, rst, cmd.take, cmd.mem_read, "read missed")
  `SEM_ASSERT_IMP(a_one_cmd, clk, rst, 1'b1, $onehot0({cmd.take, cmd.mem_read, cmd.upd}), "cmd clash")
endmodule
`default_nettype wire

// ----- sim/sobel_edge_magnitude_rgba_test.sv -----
// self-checking testbench for the rgba sobel edge magnitude block
`default_nettype none
module sobel_edge_magnitude_rgba_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sem_pkg::*;

  localparam int unsigned LINE_MAX = 1024;
  localparam int unsigned FILTERED = 3;
  localparam int unsigned SETTLE = 40;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  typedef struct {
    bit drain;
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit [7:0] alpha;
  } pixel_word_t;

  typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit [7:0] alpha;
    bit last;
  } edge_word_t;

  class edge_scoreboard;
    bit [31:0] upper_row[LINE_MAX];
    bit [31:0] lower_row[LINE_MAX];
    bit [31:0] win[9];
    int unsigned col;
    int unsigned row;
    int unsigned owed_drain;
    int unsigned width_reg;
    int unsigned height_reg;
    edge_word_t owed[$];
    int errors;
    int unsigned checked;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        lower_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col = 0;
      row = 0;
      owed_drain = 0;
      width_reg = 640;
      height_reg = 480;
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned line_len();
      if (width_reg < 2) return 2;
      if (width_reg > LINE_MAX) return LINE_MAX;
      return width_reg;
    endfunction

    function int unsigned frame_rows();
      return (height_reg < 2) ? 2 : height_reg;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
      if (idx == RegWidth) width_reg = d[10:0];
      else width_reg = width_reg;
      if (idx == RegHeight) height_reg = d;
    endfunction

    function int tap(int unsigned r, int unsigned c, int unsigned ch);
      return int'(win[r * 3 + c][8 * ch +: 8]);
    endfunction

    function bit [7:0] capped_sqrt(int unsigned s);
      int unsigned r;
      int unsigned t;
      r = 0;
      if (s >= 65536) return 8'd255;
      for (int b = 7; b >= 0; b--) begin
        t = r | (1 << b);
        if (t * t <= s) r = t;
      end
      return r[7:0];
    endfunction

    function void slide(bit [31:0] top, bit [31:0] mid, bit [31:0] bot);
      bit [31:0] cin[3];
      cin[0] = top;
      cin[1] = mid;
      cin[2] = bot;
      for (int j = 0; j < 3; j++) begin
        win[j * 3] = win[j * 3 + 1];
        win[j * 3 + 1] = win[j * 3 + 2];
        win[j * 3 + 2] = cin[j];
      end
    endfunction

    function void gradient(int unsigned cr, int unsigned cc, int unsigned ci,
                           int unsigned w, int unsigned h, bit last);
      int unsigned rs[3];
      int unsigned cs[3];
      int wt[3];
      int gx;
      int gy;
      bit [7:0] v[4];
      edge_word_t e;
      wt = '{1, 2, 1};
      rs[0] = (cr == 0) ? 1 : 0;
      rs[1] = 1;
      rs[2] = (cr + 1 >= h) ? 1 : 2;
      cs[0] = (cc == 0) ? ci : ci - 1;
      cs[1] = ci;
      cs[2] = (cc + 1 >= w) ? ci : ci + 1;
      if (cs[2] > 2) cs[2] = 2;
      for (int ch = 0; ch < 4; ch++) begin
        if (ch < FILTERED) begin
          gx = 0;
          gy = 0;
          for (int j = 0; j < 3; j++) begin
            gx += wt[j] * (tap(rs[j], cs[2], ch) - tap(rs[j], cs[0], ch));
            gy += wt[j] * (tap(rs[0], cs[j], ch) - tap(rs[2], cs[j], ch));
          end
          v[ch] = capped_sqrt(gx * gx + gy * gy);
        end else begin
          v[ch] = 8'(tap(1, ci, ch));
        end
      end
      e.red = v[0];
      e.green = v[1];
      e.blue = v[2];
      e.alpha = v[3];
      e.last = last;
      owed.push_back(e);
    endfunction

    function void note_input(pixel_word_t x);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      int unsigned k;
      bit [31:0] px;
      bit [31:0] up;
      bit [31:0] lo;
      bit due;
      w = line_len();
      h = frame_rows();
      if (!x.drain) begin
        px = {x.alpha, x.blue, x.green, x.red};
        owed_drain = 0;
        if (col >= w) begin
          col = 0;
          row++;
        end
        r = row;
        c = col;
        due = (r >= 2) || (r == 1 && c >= 1);
        up = upper_row[c];
        lo = lower_row[c];
        upper_row[c] = lo;
        lower_row[c] = px;
        if (c == 0) begin
          if (due) gradient(r - 2, w - 1, 2, w, h, 1'b0);
          slide(up, lo, px);
        end else begin
          slide(up, lo, px);
          if (due) gradient(r - 1, c - 1, 1, w, h, 1'b0);
        end
        if (c + 1 >= w) begin
          col = 0;
          if (r + 1 >= h) begin
            row = 0;
            owed_drain = w + 1;
          end else begin
            row = r + 1;
          end
        end else begin
          col = c + 1;
        end
      end else if (owed_drain != 0) begin
        k = (owed_drain >= w + 1) ? 0 : w + 1 - owed_drain;
        if (k == 0) begin
          gradient(h - 2, w - 1, 2, w, h, 1'b0);
          slide(upper_row[0], lower_row[0], '0);
        end else if (k < w) begin
          slide(upper_row[k], lower_row[k], '0);
          gradient(h - 1, k - 1, 1, w, h, 1'b0);
        end else begin
          gradient(h - 1, w - 1, 2, w, h, 1'b1);
        end
        owed_drain--;
      end
    endfunction

    function void check(edge_word_t a);
      edge_word_t e;
      checked++;
      if (owed.size() == 0) begin
        $error("edge word with none expected");
        errors++;
        return;
      end
      e = owed.pop_front();
      if (a.red != e.red) begin
        $error("red_edge expected %0d actual %0d", e.red, a.red);
        errors++;
      end
      if (a.green != e.green) begin
        $error("green_edge expected %0d actual %0d", e.green, a.green);
        errors++;
      end
      if (a.blue != e.blue) begin
        $error("blue_edge expected %0d actual %0d", e.blue, a.blue);
        errors++;
      end
      if (a.alpha != e.alpha) begin
        $error("alpha_out expected %0d actual %0d", e.alpha, a.alpha);
        errors++;
      end
      if (a.last != e.last) begin
        $error("frame_last expected %0d actual %0d", e.last, a.last);
        errors++;
      end
    endfunction

    // pixels still needed to close the current frame
    function int unsigned left_in_frame();
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned n;
      w = line_len();
      h = frame_rows();
      c = col;
      r = row;
      if (c >= w) begin
        c = 0;
        r++;
      end
      n = w - c;
      if (r + 1 < h) n += (h - 1 - r) * w;
      return n;
    endfunction
  endclass

  logic clk;
  logic rst;
  sem_in_if in_ch();
  sem_out_if out_ch();
  sem_cfg_if cfg_ch();

  edge_scoreboard sb;
  bit want_hold;
  bit steady;
  longint unsigned cycles;
  int unsigned words_in;
  int unsigned frames;

  sobel_edge_magnitude_rgba u_top (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    pixel_word_t x;
    edge_word_t a;
    if (!rst && in_ch.valid && in_ch.ready) begin
      x.drain = in_ch.req_type;
      x.red = in_ch.red_in;
      x.green = in_ch.green_in;
      x.blue = in_ch.blue_in;
      x.alpha = in_ch.alpha_in;
      sb.note_input(x);
      words_in++;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      a.red = out_ch.red_edge;
      a.green = out_ch.green_edge;
      a.blue = out_ch.blue_edge;
      a.alpha = out_ch.alpha_out;
      a.last = out_ch.frame_last;
      sb.check(a);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // output side stalls
  initial begin
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (want_hold) begin
        want_hold = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!steady && $urandom_range(7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic push_word(pixel_word_t x);
    int unsigned g;
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= x.drain;
    in_ch.red_in <= x.red;
    in_ch.green_in <= x.green;
    in_ch.blue_in <= x.blue;
    in_ch.alpha_in <= x.alpha;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic pixels(int unsigned n, int unsigned noise_pct);
    pixel_word_t x;
    for (int unsigned i = 0; i < n; i++) begin
      x.red = 8'($urandom);
      x.green = 8'($urandom);
      x.blue = 8'($urandom);
      x.alpha = 8'($urandom);
      x.drain = 1'b0;
      if ($urandom_range(99) < noise_pct) begin
        x.drain = 1'b1;
        push_word(x);
        x.drain = 1'b0;
      end
      push_word(x);
    end
  endtask

  task automatic drains(int unsigned n);
    pixel_word_t x;
    for (int unsigned i = 0; i < n; i++) begin
      x.drain = 1'b1;
      x.red = 8'($urandom);
      x.green = 8'($urandom);
      x.blue = 8'($urandom);
      x.alpha = 8'($urandom);
      push_word(x);
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, d);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic fixed_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit [7:0] a);
    pixel_word_t x;
    x.drain = 1'b0;
    x.red = r;
    x.green = g;
    x.blue = b;
    x.alpha = a;
    push_word(x);
  endtask

  initial begin
    int unsigned w;
    int unsigned n;
    int unsigned roll;
    sb = new();
    want_hold = 1'b0;
    steady = 1'b0;
    cycles = 0;
    words_in = 0;
    frames = 0;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= 1'b0;
    in_ch.red_in <= '0;
    in_ch.green_in <= '0;
    in_ch.blue_in <= '0;
    in_ch.alpha_in <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= RegWidth;
    cfg_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // drain with nothing owed, then a 2x2 frame from clamped registers
    drains(1);
    settle();
    write_reg(RegWidth, 16'd0);
    write_reg(RegHeight, 16'd1);
    fixed_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    fixed_pixel(8'hff, 8'hff, 8'hff, 8'hff);
    fixed_pixel(8'hff, 8'h00, 8'hff, 8'h00);
    fixed_pixel(8'h00, 8'hff, 8'h00, 8'hff);
    drains(4);
    settle();
    write_reg(RegWidth, 16'd1);

    // pixel abandons pending drains
    write_reg(RegWidth, 16'd3);
    write_reg(RegHeight, 16'd2);
    pixels(6, 0);
    drains(2);
    pixels(sb.left_in_frame(), 0);

    // width shrink in the middle of draining
    drains(2);
    settle();
    write_reg(RegWidth, 16'd2);
    drains(3);
    settle();

    // width shrink mid-row, tallest height, then height cut
    write_reg(RegWidth, 16'd6);
    write_reg(RegHeight, 16'hffff);
    pixels(9, 0);
    settle();
    write_reg(RegWidth, 16'd3);
    pixels(6, 0);
    settle();
    write_reg(RegHeight, 16'd3);
    pixels(sb.left_in_frame(), 0);
    drains(4);
    settle();

    // saturated width register, then a cut to a short line mid-row
    write_reg(RegWidth, 16'h07ff);
    write_reg(RegHeight, 16'd0);
    pixels(8, 0);
    settle();
    write_reg(RegWidth, 16'd4);
    pixels(sb.left_in_frame(), 0);
    drains(5);
    settle();

    // receiver held off while pixels keep coming
    write_reg(RegHeight, 16'd4);
    want_hold = 1'b1;
    steady = 1'b1;
    pixels(sb.left_in_frame(), 0);
    steady = 1'b0;
    drains(5);
    settle();

    // random frames
    n = 0;
    while (n < 950) begin
      if ($urandom_range(2) == 0) begin
        settle();
        roll = $urandom_range(99);
        if (roll < 5) write_reg(RegWidth, 16'($urandom_range(1)));
        else if (roll < 8) write_reg(RegWidth, 16'($urandom_range(40, 13)));
        else write_reg(RegWidth, 16'($urandom_range(12, 2)));
        roll = $urandom_range(99);
        if (roll < 8) write_reg(RegHeight, 16'($urandom_range(1)));
        else write_reg(RegHeight, 16'($urandom_range(5, 2)));
      end
      if (sb.line_len() > 12 && sb.left_in_frame() > 3000) begin
        settle();
        write_reg(RegHeight, 16'd2);
      end
      steady = ($urandom_range(9) == 0);
      if ($urandom_range(19) == 0) want_hold = 1'b1;
      w = sb.line_len();
      n += sb.left_in_frame();
      pixels(sb.left_in_frame(), 4);
      roll = $urandom_range(99);
      if (roll < 70) begin
        drains(w + 1);
        n += w + 1;
      end else if (roll < 85) begin
        drains($urandom_range(w));
        if ($urandom_range(3) == 0) settle();
      end else begin
        drains(w + 1 + $urandom_range(3, 1));
        n += w + 1;
      end
      frames++;
    end
    steady = 1'b0;
    settle();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d input words, %0d edge words, %0d random frames",
      words_in, sb.checked, frames);
    $display("clamped and extreme registers, abandoned drains, mid-row and mid-drain resize");
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sobel_edge_magnitude_rgba.f -----
+incdir+src
src/sem_pkg.sv
src/sem_if.sv
src/sem_ctrl.sv
src/sem_dp.sv
src/sobel_edge_magnitude_rgba.sv
sim/sobel_edge_magnitude_rgba_test.sv
